[design/ndl_pkg.sv]
// Package for the name dictionary lookup: payload structs, command codes,
// sizes and the front-to-back job struct. No dependencies.
`default_nettype none
package ndl_pkg;
    localparam int MaxEntries  = 128;
    localparam int LinearLimit = 16;
    localparam int NodeCount   = MaxEntries + 1;
    localparam int EntryW      = $clog2(MaxEntries);
    localparam int NodeW       = $clog2(NodeCount);
    localparam int QDepth      = 2;

    typedef enum logic [1:0] {
        CMD_NAME   = 2'd0,
        CMD_NODE   = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    localparam logic CFG_ENTRY_COUNT   = 1'b0;
    localparam logic CFG_RECORD_STRIDE = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  slot;
        logic [63:0] name_low;
        logic [63:0] name_high;
        logic [7:0]  node_bit;
        logic [7:0]  node_left;
        logic [7:0]  node_right;
        logic [7:0]  node_entry;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [6:0]  entry_index;
        logic [22:0] record_offset;
    } t_out_item;

    // Command handed from the front to the back: store write or lookup.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  slot;
        logic        trie_mode;
        logic [63:0] name_low;
        logic [63:0] name_high;
        logic [7:0]  node_bit;
        logic [7:0]  node_left;
        logic [7:0]  node_right;
        logic [7:0]  node_entry;
    } t_job;
endpackage
`default_nettype wire

[design/ndl_front.sv]
// Front part: accepts input beats, classifies them and queues them for the back.
// Depends on ndl_pkg.
`default_nettype none
module ndl_front import ndl_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire t_in_item i_item,
    input  wire logic [7:0] i_entry_count,
    output logic          o_job_valid,
    output t_job          o_job,
    input  wire logic     i_job_take
);
    t_job r_q [QDepth];
    logic r_rd, r_wr;
    logic [1:0] r_cnt;
    logic acc, do_push;

    assign full    = (r_cnt == 2'(QDepth));
    assign acc     = push && !full;
    // drop unused commands here; everything else keeps its order through the queue
    assign do_push = acc && t_cmd'(i_item.cmd) != CMD_NONE;

    assign o_job_valid = r_cnt != 2'd0;
    assign o_job       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr] <= '{cmd: i_item.cmd, slot: i_item.slot,
                           trie_mode: i_entry_count >= 8'(LinearLimit),
                           name_low: i_item.name_low, name_high: i_item.name_high,
                           node_bit: i_item.node_bit, node_left: i_item.node_left,
                           node_right: i_item.node_right, node_entry: i_item.node_entry};
        end
        if (!i_rst_n) begin
            r_rd <= 1'b0;
            r_wr <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wr <= ~r_wr;
            if (i_job_take && o_job_valid) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(do_push) - 2'(i_job_take && o_job_valid);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'(QDepth))
        else $error("job queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_job_valid && !i_job_take) |=> $stable(o_job)) else $error("queued job changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !i_job_take) |=> o_job_valid) else $error("job lost");
endmodule
`default_nettype wire

[design/ndl_back.sv]
// Back part: holds the name and node memories, applies store writes in order and
// runs one lookup at a time, one memory read per step, then a full compare and
// the offset multiply. Depends on ndl_pkg.
`default_nettype none
module ndl_back import ndl_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic [7:0]  i_entry_count,
    input  wire logic [15:0] i_stride,
    input  wire logic     i_job_valid,
    input  wire t_job     i_job,
    output logic          o_job_take,
    output logic          empty,
    input  wire logic     pop,
    output t_out_item     o_res
);
    typedef enum logic [2:0] {
        S_IDLE, S_LIN, S_ROOT, S_WALK, S_CAND, S_CMP, S_MUL, S_OUT
    } t_state;

    logic [63:0] r_mem_lo [MaxEntries];
    logic [63:0] r_mem_hi [MaxEntries];
    logic [31:0] r_mem_nd [NodeCount];     // bit, left, right, entry

    t_state r_st;
    t_job r_job;
    logic [NodeW-1:0] n_na;
    logic [EntryW-1:0] n_ea;
    logic [31:0] r_nd;
    logic [63:0] r_lo, r_hi;
    logic [7:0] r_idx, r_prev;
    logic r_oob, r_hit, r_full;
    t_out_item r_out;
    logic [22:0] r_prod;

    logic [7:0] nd_bit, nd_left, nd_right, nd_entry;
    logic tbit, cand_ok, eq;
    logic [7:0] child;
    logic name_we, node_we;

    // out-of-range node numbers read as all-zero nodes
    assign nd_bit   = r_oob ? 8'd0 : r_nd[31:24];
    assign nd_left  = r_oob ? 8'd0 : r_nd[23:16];
    assign nd_right = r_oob ? 8'd0 : r_nd[15:8];
    assign nd_entry = r_oob ? 8'd0 : r_nd[7:0];
    assign tbit  = nd_bit[7] ? 1'b0 :
                   (nd_bit[6] ? r_job.name_high[nd_bit[5:0]] : r_job.name_low[nd_bit[5:0]]);
    assign child = tbit ? nd_right : nd_left;
    assign eq    = r_lo == r_job.name_low && r_hi == r_job.name_high;
    assign cand_ok = r_idx < i_entry_count && r_idx < 8'(MaxEntries);

    assign o_job_take = r_st == S_IDLE && i_job_valid;
    assign name_we = o_job_take && t_cmd'(i_job.cmd) == CMD_NAME
                     && i_job.slot < 8'(MaxEntries);
    assign node_we = o_job_take && t_cmd'(i_job.cmd) == CMD_NODE
                     && i_job.slot < 8'(NodeCount);
    assign empty = !r_full;
    assign o_res = r_out;

    always_comb begin
        n_na = '0;
        n_ea = r_idx[EntryW-1:0];
        unique case (r_st)
            S_IDLE:  n_na = '0;
            S_WALK:  n_na = child[NodeW-1:0];
            S_ROOT:  n_na = nd_left[NodeW-1:0];
            default: n_na = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (name_we) begin
            r_mem_lo[i_job.slot[EntryW-1:0]] <= i_job.name_low;
            r_mem_hi[i_job.slot[EntryW-1:0]] <= i_job.name_high;
        end
        if (node_we) begin
            r_mem_nd[i_job.slot[NodeW-1:0]] <= {i_job.node_bit, i_job.node_left,
                                                i_job.node_right, i_job.node_entry};
        end
        r_nd <= r_mem_nd[n_na];
        r_lo <= r_mem_lo[n_ea];
        r_hi <= r_mem_hi[n_ea];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_full <= 1'b0;
        end else begin
            if (pop && r_full) r_full <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    r_oob <= 1'b0;
                    r_idx <= 8'd0;
                    // store writes finish on the take edge; only lookups leave idle
                    if (o_job_take && t_cmd'(i_job.cmd) == CMD_LOOKUP) begin
                        r_job <= i_job;
                        r_st <= i_job.trie_mode ? S_ROOT : S_LIN;
                    end
                end
                S_LIN: begin
                    // data for r_idx arrives next cycle; compare in S_CMP
                    r_st <= (r_idx < i_entry_count) ? S_CMP : S_MUL;
                    r_hit <= 1'b0;
                end
                S_ROOT: begin
                    r_prev <= nd_bit;
                    if (nd_left == 8'd0) begin
                        r_hit <= 1'b0;
                        r_st <= S_MUL;
                    end else begin
                        r_oob <= nd_left > 8'(MaxEntries);
                        r_st <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_prev > nd_bit) begin
                        r_prev <= nd_bit;
                        r_oob <= child > 8'(MaxEntries);
                    end else begin
                        r_idx <= nd_entry;
                        r_st <= S_CAND;
                    end
                end
                S_CAND: begin
                    r_st <= S_CMP;
                end
                S_CMP: begin
                    if (cand_ok && eq) begin
                        r_hit <= 1'b1;
                        r_st <= S_MUL;
                    end else if (!r_job.trie_mode && r_idx + 8'd1 < i_entry_count) begin
                        r_idx <= r_idx + 8'd1;
                        r_st <= S_CAND;
                    end else begin
                        r_hit <= 1'b0;
                        r_st <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= {7'd0, i_stride} * {16'd0, r_idx[6:0]};
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (!r_full) begin
                        r_out <= r_hit ? '{found: 1'b1, entry_index: r_idx[6:0],
                                           record_offset: r_prod + 23'd4}
                                       : '0;
                        r_full <= 1'b1;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT && !r_full) |=> r_full) else $error("result not stored");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_job_take && t_cmd'(i_job.cmd) == CMD_LOOKUP) |=> r_st != S_IDLE)
        else $error("job dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && !pop) |=> $stable(r_out)) else $error("result changed while held");
endmodule
`default_nettype wire

[design/name_dictionary_lookup.sv]
// Top level of the name dictionary lookup: configuration registers, front and back.
// Depends on ndl_pkg, ndl_front, ndl_back.
//
// Input channel: a queue interface (push/full); CMD_NONE beats are dropped. Every other
// command passes through a two-deep job queue to the back, which applies a store write
// as it takes it and runs lookups in order: a lookup sees every write accepted before it.
// Result channel: a queue interface (empty/pop), one result per lookup; the result
// register holds it until popped, the back waits meanwhile and the queue then fills.
// Configuration: cfg_valid/cfg_ready channel, index 0 entry_count, 1 record_stride;
// always ready, write only while idle.
// A linear lookup reads and compares the entries in order until one matches; a trie
// lookup reads the root, walks the nodes, then reads and compares the candidate; an empty
// dictionary or an empty trie skips the compare. The walk is bound by the single read
// port of the node memory, the scan by the name memory port.
// One lookup is in the back at a time; a write does not take the back out of idle.
// Reset clears the registers and queues; store contents stay undefined until written.
`default_nettype none
module name_dictionary_lookup import ndl_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire t_in_item   i_item,
    output logic            empty,
    input  wire logic       pop,
    output t_out_item       o_item,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    logic [7:0]  r_count;
    logic [15:0] r_stride;
    logic job_valid, job_take;
    t_job job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 8'd0;
            r_stride <= 16'd0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_ENTRY_COUNT) r_count <= i_cfg_data[7:0];
            if (i_cfg_index == CFG_RECORD_STRIDE) r_stride <= i_cfg_data;
        end
    end

    ndl_front u_front (
        .i_clk, .i_rst_n, .push, .full, .i_item,
        .i_entry_count(r_count), .o_job_valid(job_valid), .o_job(job),
        .i_job_take(job_take)
    );

    ndl_back u_back (
        .i_clk, .i_rst_n,
        .i_entry_count(r_count), .i_stride(r_stride),
        .i_job_valid(job_valid), .i_job(job), .o_job_take(job_take),
        .empty, .pop, .o_res(o_item)
    );
endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// Testbench for name_dictionary_lookup: directed table, then random phases that build
// Patricia tries and scan linear dictionaries. Depends on ndl_pkg and the block's RTL.
`default_nettype none
module tb;
    import ndl_pkg::*;

    localparam int CycleLimit  = 600000;
    localparam int SettleWait  = 60;
    localparam int TotalItems  = 850;

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_item;
    logic      empty;
    logic      pop;
    t_out_item o_item;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic      i_cfg_index;
    logic [15:0] i_cfg_data;

    name_dictionary_lookup uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_item(o_item), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Shadow of the dictionary and its registers
    logic [63:0] name_lo_mem [MaxEntries];
    logic [63:0] name_hi_mem [MaxEntries];
    logic [7:0]  node_bit_mem [NodeCount];
    logic [7:0]  node_left_mem [NodeCount];
    logic [7:0]  node_right_mem [NodeCount];
    logic [7:0]  node_entry_mem [NodeCount];
    logic [7:0]  entry_count;
    logic [15:0] record_stride;
    logic [7:0]  root_bit;

    t_out_item pending_results [$];
    bit        failed;
    bit        rst_done;
    int        cycles;
    int        beats;
    int        hold;
    int        hits;
    int        lookups;
    int        inserts;
    int        items_sent;

    typedef struct {
        logic [7:0]  cnt;
        logic [15:0] strd;
        t_in_item    item;
        bit          typed;
        t_out_item   res;
    } t_row;
    t_row directed [$];

    initial begin
        i_clk = 1'b0;
        forever begin
            #1 i_clk = 1'b1;
            #1 i_clk = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [7:0] rd_nbit(int n);
        return n < NodeCount ? node_bit_mem[n] : 8'd0;
    endfunction
    function automatic logic [7:0] rd_nleft(int n);
        return n < NodeCount ? node_left_mem[n] : 8'd0;
    endfunction
    function automatic logic [7:0] rd_nright(int n);
        return n < NodeCount ? node_right_mem[n] : 8'd0;
    endfunction
    function automatic logic [7:0] rd_nentry(int n);
        return n < NodeCount ? node_entry_mem[n] : 8'd0;
    endfunction

    function automatic logic key_bit(logic [63:0] lo, logic [63:0] hi, int b);
        if (b < 64) return lo[b];
        if (b < 128) return hi[b-64];
        return 1'b0;
    endfunction

    // Descend while the tested bit keeps falling; return the node reached
    function automatic int trie_leaf(logic [63:0] lo, logic [63:0] hi);
        int cur;
        int nb;
        int prev;
        cur  = rd_nleft(0);
        nb   = rd_nbit(cur);
        prev = rd_nbit(0);
        while (prev > nb) begin
            prev = nb;
            cur  = key_bit(lo, hi, nb) ? rd_nright(cur) : rd_nleft(cur);
            nb   = rd_nbit(cur);
        end
        return cur;
    endfunction

    function automatic bit name_equal(int idx, logic [63:0] lo, logic [63:0] hi);
        if (idx >= entry_count || idx >= MaxEntries) return 1'b0;
        return name_lo_mem[idx] == lo && name_hi_mem[idx] == hi;
    endfunction

    function automatic t_out_item lookup_result(logic [63:0] lo, logic [63:0] hi);
        t_out_item r;
        int        c;
        r = '0;
        c = -1;
        if (entry_count < LinearLimit) begin
            for (int i = 0; i < entry_count && i < MaxEntries; i++)
                if (c < 0 && name_equal(i, lo, hi)) c = i;
        end else if (rd_nleft(0) != 0) begin
            c = rd_nentry(trie_leaf(lo, hi));
            if (!name_equal(c, lo, hi)) c = -1;
        end
        if (c >= 0) begin
            r.found         = 1'b1;
            r.entry_index   = c[6:0];
            r.record_offset = 23'(4 + int'(record_stride) * c);
        end
        return r;
    endfunction

    function automatic void store_write(t_in_item it);
        if (it.cmd == CMD_NAME && it.slot < MaxEntries) begin
            name_lo_mem[it.slot] = it.name_low;
            name_hi_mem[it.slot] = it.name_high;
        end else if (it.cmd == CMD_NODE && it.slot < NodeCount) begin
            node_bit_mem[it.slot]   = it.node_bit;
            node_left_mem[it.slot]  = it.node_left;
            node_right_mem[it.slot] = it.node_right;
            node_entry_mem[it.slot] = it.node_entry;
        end
    endfunction

    function automatic t_in_item mk_item(t_cmd c, int s, logic [63:0] lo,
                                         logic [63:0] hi, int nb, int nl,
                                         int nr, int ne);
        t_in_item it;
        it.cmd = c; it.slot = 8'(s); it.name_low = lo; it.name_high = hi;
        it.node_bit = 8'(nb); it.node_left = 8'(nl); it.node_right = 8'(nr);
        it.node_entry = 8'(ne);
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one beat and hold it until taken; record what it should produce
    task automatic send(t_in_item it, bit typed = 1'b0, t_out_item res = '0);
        int g;
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        items_sent++;
        if (it.cmd == CMD_LOOKUP) begin
            lookups++;
            pending_results.push_back(typed ? res : lookup_result(it.name_low, it.name_high));
        end else begin
            store_write(it);
        end
        g = gap_len();
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SettleWait) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_ENTRY_COUNT) entry_count = data[7:0];
        else record_stride = data;
        @(posedge i_clk);
    endtask

    task automatic set_regs(logic [7:0] cnt, logic [15:0] strd);
        drain();
        cfg_write(CFG_ENTRY_COUNT, {8'd0, cnt});
        cfg_write(CFG_RECORD_STRIDE, strd);
    endtask

    task automatic lookup(logic [63:0] lo, logic [63:0] hi);
        send(mk_item(CMD_LOOKUP, $urandom, lo, hi, $urandom, $urandom, $urandom, $urandom));
    endtask

    // Patricia insertion of entry k on node k+1; drop keys already present
    task automatic trie_insert(int k, logic [63:0] lo, logic [63:0] hi);
        int c;
        int d;
        int cur;
        int par;
        int prev;
        t_in_item pn;
        if (k == 0) begin
            send(mk_item(CMD_NAME, 0, lo, hi, $urandom, $urandom, $urandom, $urandom));
            send(mk_item(CMD_NODE, 1, rand64(), rand64(), 127, 1, 1, 0));
            send(mk_item(CMD_NODE, 0, rand64(), rand64(), root_bit, 1,
                         node_right_mem[0], node_entry_mem[0]));
            inserts++;
            return;
        end
        c = rd_nentry(trie_leaf(lo, hi));
        if (c >= MaxEntries) return;
        d = -1;
        for (int b = 127; b >= 0; b--)
            if (d < 0 && key_bit(lo, hi, b) != key_bit(name_lo_mem[c], name_hi_mem[c], b))
                d = b;
        if (d < 0) return;
        par  = 0;
        cur  = rd_nleft(0);
        prev = rd_nbit(0);
        while (rd_nbit(cur) < prev && rd_nbit(cur) > d) begin
            par  = cur;
            prev = rd_nbit(cur);
            cur  = key_bit(lo, hi, prev) ? rd_nright(cur) : rd_nleft(cur);
        end
        send(mk_item(CMD_NAME, k, lo, hi, $urandom, $urandom, $urandom, $urandom));
        if (key_bit(lo, hi, d))
            send(mk_item(CMD_NODE, k + 1, rand64(), rand64(), d, cur, k + 1, k));
        else
            send(mk_item(CMD_NODE, k + 1, rand64(), rand64(), d, k + 1, cur, k));
        pn = mk_item(CMD_NODE, par, rand64(), rand64(), node_bit_mem[par],
                     node_left_mem[par], node_right_mem[par], node_entry_mem[par]);
        if (par != 0 && key_bit(lo, hi, node_bit_mem[par])) pn.node_right = 8'(k+1);
        else pn.node_left = 8'(k+1);
        send(pn);
        inserts++;
    endtask

    task automatic add_row(logic [7:0] cnt, logic [15:0] strd, t_in_item it,
                           bit typed = 1'b0, t_out_item res = '0);
        t_row r;
        r.cnt = cnt; r.strd = strd; r.item = it; r.typed = typed; r.res = res;
        directed.push_back(r);
    endtask

    // Check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (!rst_done) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                beats++;
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    failed = 1'b1;
                end else begin
                    want = pending_results.pop_front();
                    if (o_item.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, o_item.found);
                        failed = 1'b1;
                    end
                    if (o_item.entry_index !== want.entry_index) begin
                        $error("entry_index: expected %0d, got %0d", want.entry_index,
                               o_item.entry_index);
                        failed = 1'b1;
                    end
                    if (o_item.record_offset !== want.record_offset) begin
                        $error("record_offset: expected %0d, got %0d", want.record_offset,
                               o_item.record_offset);
                        failed = 1'b1;
                    end
                    if (want.found) hits++;
                end
                // hold off for a long stretch once so the input side backs up
                hold = (beats == 150) ? 500 : gap_len();
            end
            if (hold > 0) begin
                hold--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        t_out_item miss;
        t_out_item h;
        logic [63:0] ones;
        logic [63:0] pat;
        logic [7:0]  cnt;
        logic [15:0] strd;
        int m;
        int k;
        int r;
        int s;
        cycles = 0; failed = 0; rst_done = 0; beats = 0; hold = 0;
        hits = 0; lookups = 0; inserts = 0; items_sent = 0;
        entry_count = '0; record_stride = '0;
        push = 1'b0; i_item = '0; i_cfg_valid = 1'b0; i_cfg_index = 1'b0; i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done = 1'b1;
        @(posedge i_clk);

        // Fill every store slot so no lookup ever touches an unwritten entry
        for (int i = 0; i < MaxEntries; i++)
            send(mk_item(CMD_NAME, i, rand64(), rand64(), 0, 0, 0, 0));
        for (int i = 0; i < NodeCount; i++)
            send(mk_item(CMD_NODE, i, 0, 0, $urandom, (i == 0) ? 0 : $urandom,
                         $urandom, $urandom));

        ones = '1;
        pat  = 64'h5555_aaaa_0f0f_f0f0;
        miss = '0;
        add_row(0, 0, mk_item(CMD_LOOKUP, 0, ones, ones, 0, 0, 0, 0), 1, miss);
        add_row(0, 0, mk_item(CMD_NONE, 255, ones, ones, 255, 255, 255, 255));
        add_row(0, 0, mk_item(CMD_NAME, 128, ones, ones, 0, 0, 0, 0));
        add_row(0, 0, mk_item(CMD_NAME, 255, 0, 0, 0, 0, 0, 0));
        add_row(0, 0, mk_item(CMD_NODE, 129, 0, 0, 255, 255, 255, 255));
        add_row(0, 0, mk_item(CMD_NODE, 255, 0, 0, 127, 1, 1, 0));
        add_row(0, 0, mk_item(CMD_NAME, 0, ones, ones, 0, 0, 0, 0));
        add_row(0, 0, mk_item(CMD_NAME, 1, 0, 0, 0, 0, 0, 0));
        add_row(0, 0, mk_item(CMD_NAME, 127, pat, ~pat, 0, 0, 0, 0));
        add_row(0, 0, mk_item(CMD_NODE, 0, 0, 0, 200, 0, 0, 0));
        h = '{found: 1'b1, entry_index: 7'd0, record_offset: 23'd4};
        add_row(2, 16'hffff, mk_item(CMD_LOOKUP, 0, ones, ones, 0, 0, 0, 0), 1, h);
        h = '{found: 1'b1, entry_index: 7'd1, record_offset: 23'd65539};
        add_row(2, 16'hffff, mk_item(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 0), 1, h);
        add_row(2, 16'hffff, mk_item(CMD_LOOKUP, 0, pat, ~pat, 0, 0, 0, 0));
        add_row(15, 16'hffff, mk_item(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 0), 1, h);
        add_row(15, 16'hffff, mk_item(CMD_LOOKUP, 0, pat, ~pat, 0, 0, 0, 0));
        add_row(128, 16'hffff, mk_item(CMD_LOOKUP, 0, ones, ones, 0, 0, 0, 0), 1, miss);
        add_row(255, 16'd1, mk_item(CMD_LOOKUP, 0, pat, ~pat, 0, 0, 0, 0), 1, miss);
        add_row(255, 16'd1, mk_item(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 0), 1, miss);

        set_regs(0, 0);
        foreach (directed[i]) begin
            if (directed[i].cnt != entry_count || directed[i].strd != record_stride)
                set_regs(directed[i].cnt, directed[i].strd);
            send(directed[i].item, directed[i].typed, directed[i].res);
        end

        while (items_sent < TotalItems) begin
            r = $urandom_range(0, 9);
            case (r)
                0: cnt = 8'd0;
                1: cnt = 8'd15;
                2: cnt = 8'd16;
                3: cnt = 8'd128;
                4: cnt = 8'd255;
                5, 6: cnt = 8'($urandom_range(1, 15));
                default: cnt = 8'($urandom_range(16, 140));
            endcase
            r = $urandom_range(0, 4);
            strd = (r == 0) ? 16'hffff : (r == 1) ? 16'd0 : 16'($urandom);
            set_regs(cnt, strd);
            if (cnt >= LinearLimit) begin
                root_bit = 8'($urandom_range(128, 255));
                send(mk_item(CMD_NODE, 0, 0, 0, root_bit, 0, $urandom, $urandom));
                lookup(rand64(), rand64());
                m = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                 : $urandom_range(1, 20);
                if (m > cnt) m = cnt;
                if (m > MaxEntries) m = MaxEntries;
                for (k = 0; k < m; k++) begin
                    // near copies of earlier keys differ in one bit and force splits at that bit
                    if (k > 0 && $urandom_range(0, 2) == 0) begin
                        s = $urandom_range(0, k - 1);
                        r = $urandom_range(0, 127);
                        trie_insert(k, name_lo_mem[s] ^ ((r < 64) ? (64'd1 << r) : 64'd0),
                                    name_hi_mem[s] ^ ((r >= 64) ? (64'd1 << (r - 64)) : 64'd0));
                    end else begin
                        trie_insert(k, rand64(), rand64());
                    end
                end
            end else begin
                m = MaxEntries;
            end
            repeat ($urandom_range(40, 80)) begin
                r = $urandom_range(0, 99);
                s = $urandom_range(0, (cnt == 0) ? 0 : ((cnt > 127) ? 127 : cnt - 1));
                if (r < 60) begin
                    lookup(name_lo_mem[s], name_hi_mem[s]);
                end else if (r < 72) begin
                    lookup(rand64(), rand64());
                end else if (r < 80) begin
                    lookup(name_lo_mem[s] ^ (64'd1 << $urandom_range(0, 63)), name_hi_mem[s]);
                end else if (r < 88) begin
                    // keep the trie intact: rewrite only slots it does not hold
                    s = $urandom_range((m >= MaxEntries) ? 0 : m, 255);
                    send(mk_item(CMD_NAME, s, rand64(), rand64(), $urandom, $urandom,
                                 $urandom, $urandom));
                end else if (r < 92) begin
                    s = $urandom_range((cnt >= LinearLimit) ? m + 1 : 0, 255);
                    send(mk_item(CMD_NODE, s, rand64(), rand64(), $urandom, $urandom,
                                 $urandom, $urandom));
                end else begin
                    send(mk_item(CMD_NONE, $urandom, rand64(), rand64(), $urandom, $urandom,
                                 $urandom, $urandom));
                end
            end
        end

        drain();
        $display("Ran %0d lookups (%0d hits) across linear and trie modes,", lookups, hits);
        $display("with %0d trie insertions and a long result-side stall.", inserts);
        if (!failed) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
design/ndl_pkg.sv
design/ndl_front.sv
design/ndl_back.sv
design/name_dictionary_lookup.sv
tb/tb.sv
